[sv/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge out of reset
`define LSWS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");

// when trig holds, expr must hold in the next cycle
`define LSWS_ASSERT_NEXT(lbl, clk, rstn, trig, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (expr)) \
		else $error("assertion failed");

`else

`define LSWS_ASSERT(lbl, clk, rstn, prop)
`define LSWS_ASSERT_NEXT(lbl, clk, rstn, trig, expr)

`endif

`endif

[sv/lsws_pkg.sv]
// types, codes and constants of the lifo stack with swap
package lsws_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_LIST = 3'd1,
		OP_PEEK = 3'd2,
		OP_POP  = 3'd3,
		OP_SWAP = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_EMPTY     = 3'd1,
		STAT_SHORT     = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_LISTEMPTY = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RESP,
		BK_SWAP_HI,
		BK_SWAP_LO
	} back_state_t;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] push_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [2:0]         status;
		logic               last_of_run;
	} out_item_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic valid;
	} queue_status_t;

endpackage

[sv/lsws_front.sv]
// front stage: accepts input items, drops unused codes, feeds the command queue
module lsws_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  lsws_pkg::in_item_t  item,
	output logic                q_push,
	output lsws_pkg::cmd_t      q_cmd,
	input  logic                q_full
);

	logic           valid_s1;
	lsws_pkg::cmd_t cmd_s1;
	logic           accept;
	logic           legal;

	assign item_stall = valid_s1 && q_full;
	assign accept     = item_valid && !item_stall;
	assign legal      = item.func <= 3'(lsws_pkg::OP_SWAP);
	assign q_push     = valid_s1 && !q_full;
	assign q_cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= legal;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op    <= lsws_pkg::op_t'(item.func);
			cmd_s1.value <= item.push_value;
		end
	end

endmodule

[sv/lsws_queue.sv]
// short command queue between front and back
module lsws_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  lsws_pkg::cmd_t           push_cmd,
	input  logic                     pop,
	output lsws_pkg::cmd_t           head,
	output lsws_pkg::queue_status_t  qstat
);

	localparam int PW = (lsws_pkg::QUEUE_DEPTH > 1) ? $clog2(lsws_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(lsws_pkg::QUEUE_DEPTH + 1);

	lsws_pkg::cmd_t slot_q [lsws_pkg::QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign qstat.full  = count_q == CW'(lsws_pkg::QUEUE_DEPTH);
	assign qstat.valid = count_q != '0;
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && qstat.valid;
	assign head        = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(lsws_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(lsws_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[sv/lsws_back.sv]
// back end: stack memory, entry count, command sequencer and result register
module lsws_back #(
	parameter int STACK_DEPTH = lsws_pkg::STACK_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  lsws_pkg::cmd_t      q_cmd,
	output logic                q_pop,
	output logic                result_valid,
	input  logic                result_stall,
	output lsws_pkg::out_item_t result
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [31:0]             mem [STACK_DEPTH];
	lsws_pkg::back_state_t   state_q, state_d;
	logic [CW-1:0]           cnt_q;
	logic [AW-1:0]           idx_q;
	logic                    list_q;
	logic                    sel_q;
	lsws_pkg::status_t       status_q;
	logic [31:0]             rd_a_q;
	logic [31:0]             rd_b_q;
	lsws_pkg::out_item_t     result_q;
	logic                    result_valid_q;

	logic [CW-1:0]           cnt_m1;
	logic [CW-1:0]           cnt_m2;
	logic [AW-1:0]           top_a;
	logic [AW-1:0]           sec_a;
	logic [AW-1:0]           idx_m1;
	logic                    is_empty;
	logic                    is_full;
	logic                    is_short;
	logic                    more;
	logic                    out_free;

	logic                    mem_we;
	logic [AW-1:0]           waddr;
	logic [31:0]             wdata;
	logic                    rd_en;
	logic [AW-1:0]           raddr;
	logic                    cmd_load;
	lsws_pkg::status_t       status_d;
	logic                    sel_d;
	logic                    list_d;
	logic                    cnt_inc;
	logic                    cnt_dec;
	logic                    idx_step;
	logic                    out_load;

	assign cnt_m1   = cnt_q - CW'(1);
	assign cnt_m2   = cnt_q - CW'(2);
	assign top_a    = cnt_m1[AW-1:0];
	assign sec_a    = cnt_m2[AW-1:0];
	assign idx_m1   = idx_q - AW'(1);
	assign is_empty = cnt_q == '0;
	assign is_full  = cnt_q == CW'(STACK_DEPTH);
	assign is_short = cnt_q < CW'(2);
	assign more     = list_q && (idx_q != '0);
	assign out_free = !result_valid_q || !result_stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lsws_pkg::BK_IDLE: begin
				if (q_valid) begin
					if (q_cmd.op == lsws_pkg::OP_SWAP && !is_short) begin
						state_d = lsws_pkg::BK_SWAP_HI;
					end else begin
						state_d = lsws_pkg::BK_RESP;
					end
				end
			end
			lsws_pkg::BK_SWAP_HI: begin
				state_d = lsws_pkg::BK_SWAP_LO;
			end
			lsws_pkg::BK_SWAP_LO: begin
				state_d = lsws_pkg::BK_RESP;
			end
			lsws_pkg::BK_RESP: begin
				if (out_free && !more) begin
					state_d = lsws_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = lsws_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		mem_we   = 1'b0;
		waddr    = top_a;
		wdata    = rd_b_q;
		rd_en    = 1'b0;
		raddr    = top_a;
		cmd_load = 1'b0;
		status_d = lsws_pkg::STAT_OK;
		sel_d    = 1'b0;
		list_d   = 1'b0;
		cnt_inc  = 1'b0;
		cnt_dec  = 1'b0;
		idx_step = 1'b0;
		out_load = 1'b0;
		case (state_q)
			lsws_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop    = 1'b1;
					cmd_load = 1'b1;
					case (q_cmd.op)
						lsws_pkg::OP_PUSH: begin
							if (is_full) begin
								status_d = lsws_pkg::STAT_FULL;
							end else begin
								mem_we  = 1'b1;
								waddr   = cnt_q[AW-1:0];
								wdata   = q_cmd.value;
								cnt_inc = 1'b1;
							end
						end
						lsws_pkg::OP_LIST: begin
							if (is_empty) begin
								status_d = lsws_pkg::STAT_LISTEMPTY;
							end else begin
								rd_en  = 1'b1;
								sel_d  = 1'b1;
								list_d = 1'b1;
							end
						end
						lsws_pkg::OP_PEEK: begin
							if (is_empty) begin
								status_d = lsws_pkg::STAT_EMPTY;
							end else begin
								rd_en = 1'b1;
								sel_d = 1'b1;
							end
						end
						lsws_pkg::OP_POP: begin
							if (is_empty) begin
								status_d = lsws_pkg::STAT_EMPTY;
							end else begin
								rd_en   = 1'b1;
								sel_d   = 1'b1;
								cnt_dec = 1'b1;
							end
						end
						lsws_pkg::OP_SWAP: begin
							if (is_short) begin
								status_d = lsws_pkg::STAT_SHORT;
							end else begin
								rd_en = 1'b1;
							end
						end
						default: begin
							status_d = lsws_pkg::STAT_OK;
						end
					endcase
				end
			end
			lsws_pkg::BK_SWAP_HI: begin
				mem_we = 1'b1;
				waddr  = top_a;
				wdata  = rd_b_q;
			end
			lsws_pkg::BK_SWAP_LO: begin
				mem_we = 1'b1;
				waddr  = sec_a;
				wdata  = rd_a_q;
			end
			lsws_pkg::BK_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					if (more) begin
						rd_en    = 1'b1;
						raddr    = idx_m1;
						idx_step = 1'b1;
					end
				end
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= lsws_pkg::BK_IDLE;
			cnt_q          <= '0;
			list_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cnt_dec) begin
				cnt_q <= cnt_m1;
			end
			if (cmd_load) begin
				list_q <= list_d;
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_load) begin
			status_q <= status_d;
			sel_q    <= sel_d;
			idx_q    <= top_a;
		end else if (idx_step) begin
			idx_q <= idx_m1;
		end
		if (out_load) begin
			result_q.result_value <= sel_q ? rd_a_q : '0;
			result_q.status       <= 3'(status_q);
			result_q.last_of_run  <= !more;
		end
	end

	// stack memory, one write and two registered reads
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_a_q <= mem[raddr];
			rd_b_q <= mem[sec_a];
		end
	end

endmodule

[sv/lifo_stack_with_swap.sv]
// top level of the lifo stack with swap: front, command queue and back
//
// channel  direction  handshake                    payload
// item     in         item_valid / item_stall      lsws_pkg::in_item_t
// result   out        result_valid / result_stall  lsws_pkg::out_item_t
//
// push, peek, pop, a refused swap and a list of an empty stack go from idle to resp
// a swap also passes swap_hi and swap_lo; a non-empty list gives one result per entry
// the stack memory has one write port, so a swap writes its entries in swap_hi and swap_lo
// a command is registered in the front, then queued until the back end pops it
// reset clears the entry count and all valid state; the memory itself is not cleared
// a stalled result holds the back end; the queue keeps taking items until it fills
`include "assert_macros.svh"

module lifo_stack_with_swap #(
	parameter int STACK_DEPTH = lsws_pkg::STACK_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  lsws_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output lsws_pkg::out_item_t result
);

	logic                    q_push;
	lsws_pkg::cmd_t          q_in;
	logic                    q_pop;
	lsws_pkg::cmd_t          q_head;
	lsws_pkg::queue_status_t qstat;
	logic                    value_ok;

	assign value_ok = result.result_value == '0 || result.status == 3'(lsws_pkg::STAT_OK);

	lsws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_push     (q_push),
		.q_cmd      (q_in),
		.q_full     (qstat.full)
	);

	lsws_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.pop      (q_pop),
		.head     (q_head),
		.qstat    (qstat)
	);

	lsws_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (qstat.valid),
		.q_cmd        (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	`LSWS_ASSERT(a_no_push_full, clk, arst_n, !(q_push && qstat.full))
	`LSWS_ASSERT(a_pop_has_item, clk, arst_n, !q_pop || qstat.valid)
	`LSWS_ASSERT(a_value_only_ok, clk, arst_n, !result_valid || value_ok)
	`LSWS_ASSERT_NEXT(a_stall_front, clk, arst_n, item_stall && !q_pop, qstat.full || !item_stall)

endmodule
